FILE: sv/wbsfc_pkg.sv
// Package for the weight-bounded swap-to-front cache.
// Holds sizes, field widths, command and result codes shared by all files.
// No dependencies.
package wbsfc_pkg;

    localparam int DEPTH     = 16;
    localparam int SLOTS     = DEPTH + 1;               // one spare slot during insert
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int CMP_W     = 8;                       // common width for count compares

    localparam int CMD_W     = 2;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 16;
    localparam int WT_W      = 32;
    localparam int KIND_W    = 3;
    localparam int ENTRY_W   = 5;
    localparam int SUM_W     = 37;

    localparam int MAXE_W    = 5;
    localparam int MLIM_W    = 12;
    localparam int MB_SHIFT  = 20;                      // 1048576 bytes per megabyte
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 12;

    localparam logic [MAXE_W-1:0] MAXE_RESET = MAXE_W'(16);
    localparam logic [MLIM_W-1:0] MLIM_RESET = MLIM_W'(16);

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MEM_LIMIT_MB = CFG_IDX_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_HIT         = 3'd0,
        KIND_MISS        = 3'd1,
        KIND_BYPASS_MISS = 3'd2,
        KIND_EVICTED     = 3'd3,
        KIND_INSERTED    = 3'd4,
        KIND_UPDATED     = 3'd5,
        KIND_DELETED     = 3'd6,
        KIND_NOT_FOUND   = 3'd7
    } kind_t;

endpackage

FILE: sv/wbsfc_req_if.sv
// Request channel of the swap-to-front cache: valid/ready plus one command beat.
// Depends on wbsfc_pkg.
interface wbsfc_req_if;
    logic                                valid;
    logic                                ready;
    logic [wbsfc_pkg::CMD_W-1:0]         cmd;
    logic [wbsfc_pkg::KEY_W-1:0]         key;
    logic [wbsfc_pkg::VAL_W-1:0]         value_handle;
    logic [wbsfc_pkg::WT_W-1:0]          weight;

    modport source (output valid, cmd, key, value_handle, weight, input ready);
    modport sink   (input valid, cmd, key, value_handle, weight, output ready);
endinterface

FILE: sv/wbsfc_rsp_if.sv
// Result channel of the swap-to-front cache: valid/ready plus one result beat.
// Depends on wbsfc_pkg.
interface wbsfc_rsp_if;
    logic                                valid;
    logic                                ready;
    wbsfc_pkg::kind_t                    kind;
    logic [wbsfc_pkg::KEY_W-1:0]         out_key;
    logic [wbsfc_pkg::VAL_W-1:0]         out_value;
    logic [wbsfc_pkg::WT_W-1:0]          out_weight;
    logic                                last;
    logic [wbsfc_pkg::ENTRY_W-1:0]       entry_count;
    logic [wbsfc_pkg::SUM_W-1:0]         total_bytes;

    modport source (output valid, kind, out_key, out_value, out_weight, last,
                    entry_count, total_bytes, input ready);
    modport sink   (input valid, kind, out_key, out_value, out_weight, last,
                    entry_count, total_bytes, output ready);
endinterface

FILE: sv/weight_bounded_swap_front_cache_top.sv
// Weight-bounded swap-to-front cache, top level. Depends on wbsfc_pkg, wbsfc_req_if
// and wbsfc_rsp_if.
//
// An ordered store of up to DEPTH entries (key, value handle, weight) with a running
// byte total. Every command is handled by one sequencer around a single registered
// read port and a single write port on the slot store, one slot per cycle, and the
// request side is ready only in the idle state. The read address is set from the step
// coming up, so the slot data is waiting in the read register when that step starts.
// Steps per command: a scan from the front up to the match, or to the count on a miss;
// a lookup hit or an update then swaps the match to the front in ST_SWAP_A and
// ST_SWAP_B; a new insert shifts the entries up one slot; a delete shifts the entries
// above the match down one slot; an insert or update then evicts from the back while
// over a limit; finally the result beats go out while the result register is free.
// All result beats of one command carry the entry count and byte total left after the
// whole command, so evictions are worked out before the first beat goes out; the
// evicted slots are still intact above the new count and are read back while emitting.
// A lookup with either limit at zero empties the store and answers a bypass miss. The
// result register parts the two sides: a new command is accepted while the final beat
// of the previous one is still waiting. The user writes configuration through cfg_we,
// cfg_index and cfg_data only while the block is idle; the block does not enforce this.
module weight_bounded_swap_front_cache_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    wbsfc_req_if.sink                         req,
    wbsfc_rsp_if.source                       rsp,
    input  logic                              cfg_we,
    input  logic [wbsfc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wbsfc_pkg::CFG_W-1:0]       cfg_data
);

    localparam int IDX_W  = wbsfc_pkg::IDX_W;
    localparam int CNT_W  = wbsfc_pkg::CNT_W;
    localparam int CMP_W  = wbsfc_pkg::CMP_W;
    localparam int KEY_W  = wbsfc_pkg::KEY_W;
    localparam int VAL_W  = wbsfc_pkg::VAL_W;
    localparam int WT_W   = wbsfc_pkg::WT_W;
    localparam int SUM_W  = wbsfc_pkg::SUM_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_INS_SHIFT,
        ST_DEL_SHIFT,
        ST_EVICT,
        ST_EMIT_FIRST,
        ST_EMIT_EVICT
    } state_t;

    // Slot store: no reset.
    logic [KEY_W-1:0] slot_key_mem    [wbsfc_pkg::SLOTS];
    logic [VAL_W-1:0] slot_value_mem  [wbsfc_pkg::SLOTS];
    logic [WT_W-1:0]  slot_weight_mem [wbsfc_pkg::SLOTS];

    // Sequencer and item registers.
    state_t                        state_reg, state_next;
    wbsfc_pkg::cmd_t               cmd_reg, cmd_next;
    logic [KEY_W-1:0]              key_reg, key_next;
    logic [VAL_W-1:0]              val_reg, val_next;
    logic [WT_W-1:0]               wt_reg, wt_next;
    logic [CNT_W-1:0]              idx_reg, idx_next;
    logic [CNT_W-1:0]              used_reg, used_next;
    logic [SUM_W-1:0]              sum_reg, sum_next;
    logic [CNT_W-1:0]              top_reg, top_next;
    logic [VAL_W-1:0]              found_val_reg, found_val_next;
    logic [WT_W-1:0]               found_wt_reg, found_wt_next;
    wbsfc_pkg::kind_t              res_kind_reg, res_kind_next;
    logic [VAL_W-1:0]              res_val_reg, res_val_next;
    logic [WT_W-1:0]               res_wt_reg, res_wt_next;

    // Configuration registers.
    logic [wbsfc_pkg::MAXE_W-1:0]  max_entries_reg, max_entries_next;
    logic [wbsfc_pkg::MLIM_W-1:0]  mem_limit_reg, mem_limit_next;

    // Result register.
    logic                          out_valid_reg, out_valid_next;
    wbsfc_pkg::kind_t              out_kind_reg, out_kind_next;
    logic [KEY_W-1:0]              out_key_reg, out_key_next;
    logic [VAL_W-1:0]              out_value_reg, out_value_next;
    logic [WT_W-1:0]               out_weight_reg, out_weight_next;
    logic                          out_last_reg, out_last_next;
    logic [CNT_W-1:0]              out_count_reg, out_count_next;
    logic [SUM_W-1:0]              out_sum_reg, out_sum_next;

    // Store ports.
    logic [IDX_W-1:0]              rd_idx;
    logic [KEY_W-1:0]              rd_key_reg;
    logic [VAL_W-1:0]              rd_val_reg;
    logic [WT_W-1:0]               rd_wt_reg;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_idx;
    logic [KEY_W-1:0]              wr_key;
    logic [VAL_W-1:0]              wr_val;
    logic [WT_W-1:0]               wr_wt;

    // Limits.
    logic                          caching_off;
    logic [CMP_W-1:0]              cap;
    logic [SUM_W-1:0]              wlim;
    logic                          over_limit;
    logic                          out_free;

    assign caching_off = (max_entries_reg == '0) || (mem_limit_reg == '0);
    assign cap = (CMP_W'(max_entries_reg) < CMP_W'(wbsfc_pkg::DEPTH))
               ? CMP_W'(max_entries_reg) : CMP_W'(wbsfc_pkg::DEPTH);
    assign wlim = SUM_W'(mem_limit_reg) << wbsfc_pkg::MB_SHIFT;
    assign over_limit = (used_reg != '0)
                     && ((CMP_W'(used_reg) > cap) || (sum_reg > wlim));
    assign out_free = !out_valid_reg || rsp.ready;

    // Single read address, chosen by the step coming up next.
    always_comb
    begin
        rd_idx = '0;
        case (state_next)
            ST_SCAN:       rd_idx = idx_next[IDX_W-1:0];
            ST_SWAP_A:     rd_idx = '0;
            ST_INS_SHIFT:  rd_idx = (idx_next != '0) ? IDX_W'(idx_next - 1'b1) : '0;
            ST_DEL_SHIFT:  rd_idx = IDX_W'(idx_next + 1'b1);
            ST_EVICT:      rd_idx = (used_next != '0) ? IDX_W'(used_next - 1'b1) : '0;
            ST_EMIT_EVICT: rd_idx = (top_next != '0) ? IDX_W'(top_next - 1'b1) : '0;
            default:       rd_idx = '0;
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        val_next         = val_reg;
        wt_next          = wt_reg;
        idx_next         = idx_reg;
        used_next        = used_reg;
        sum_next         = sum_reg;
        top_next         = top_reg;
        found_val_next   = found_val_reg;
        found_wt_next    = found_wt_reg;
        res_kind_next    = res_kind_reg;
        res_val_next     = res_val_reg;
        res_wt_next      = res_wt_reg;
        max_entries_next = max_entries_reg;
        mem_limit_next   = mem_limit_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_kind_next    = out_kind_reg;
        out_key_next     = out_key_reg;
        out_value_next   = out_value_reg;
        out_weight_next  = out_weight_reg;
        out_last_next    = out_last_reg;
        out_count_next   = out_count_reg;
        out_sum_next     = out_sum_reg;
        wr_en            = 1'b0;
        wr_idx           = '0;
        wr_key           = key_reg;
        wr_val           = val_reg;
        wr_wt            = wt_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                wbsfc_pkg::REG_MAX_ENTRIES:
                    max_entries_next = cfg_data[wbsfc_pkg::MAXE_W-1:0];
                wbsfc_pkg::REG_MEM_LIMIT_MB:
                    mem_limit_next = cfg_data[wbsfc_pkg::MLIM_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next = wbsfc_pkg::cmd_t'(req.cmd);
                    key_next = req.key;
                    val_next = req.value_handle;
                    wt_next  = req.weight;
                    idx_next = '0;
                    case (wbsfc_pkg::cmd_t'(req.cmd))
                        wbsfc_pkg::CMD_LOOKUP:
                        begin
                            if (caching_off)
                            begin
                                // Drop the whole store and answer a bypass miss.
                                used_next     = '0;
                                sum_next      = '0;
                                top_next      = '0;
                                res_kind_next = wbsfc_pkg::KIND_BYPASS_MISS;
                                res_val_next  = '0;
                                res_wt_next   = '0;
                                state_next    = ST_EMIT_FIRST;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        wbsfc_pkg::CMD_INSERT,
                        wbsfc_pkg::CMD_DELETE:
                            state_next = ST_SCAN;
                        default: ;   // unused command: no beat, no change
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (idx_reg == used_reg)
                begin
                    res_val_next = '0;
                    res_wt_next  = '0;
                    top_next     = used_reg;
                    case (cmd_reg)
                        wbsfc_pkg::CMD_INSERT:
                            state_next = ST_INS_SHIFT;   // idx already at the count
                        wbsfc_pkg::CMD_DELETE:
                        begin
                            res_kind_next = wbsfc_pkg::KIND_NOT_FOUND;
                            state_next    = ST_EMIT_FIRST;
                        end
                        default:
                        begin
                            res_kind_next = wbsfc_pkg::KIND_MISS;
                            state_next    = ST_EMIT_FIRST;
                        end
                    endcase
                end
                else if (rd_key_reg == key_reg)
                begin
                    found_val_next = rd_val_reg;
                    found_wt_next  = rd_wt_reg;
                    case (cmd_reg)
                        wbsfc_pkg::CMD_DELETE:
                        begin
                            res_kind_next = wbsfc_pkg::KIND_DELETED;
                            res_val_next  = rd_val_reg;
                            res_wt_next   = rd_wt_reg;
                            sum_next      = sum_reg - SUM_W'(rd_wt_reg);
                            state_next    = ST_DEL_SHIFT;
                        end
                        default:
                            state_next = ST_SWAP_A;
                    endcase
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_SWAP_A:
            begin
                // Move the front entry into the slot of the match.
                wr_en      = 1'b1;
                wr_idx     = idx_reg[IDX_W-1:0];
                wr_key     = rd_key_reg;
                wr_val     = rd_val_reg;
                wr_wt      = rd_wt_reg;
                state_next = ST_SWAP_B;
            end

            ST_SWAP_B:
            begin
                wr_en    = 1'b1;
                wr_idx   = '0;
                wr_key   = key_reg;
                top_next = used_reg;
                if (cmd_reg == wbsfc_pkg::CMD_INSERT)
                begin
                    wr_val        = val_reg;
                    wr_wt         = wt_reg;
                    sum_next      = sum_reg + SUM_W'(wt_reg) - SUM_W'(found_wt_reg);
                    res_kind_next = wbsfc_pkg::KIND_UPDATED;
                    res_val_next  = val_reg;
                    res_wt_next   = wt_reg;
                    state_next    = ST_EVICT;
                end
                else
                begin
                    wr_val        = found_val_reg;
                    wr_wt         = found_wt_reg;
                    res_kind_next = wbsfc_pkg::KIND_HIT;
                    res_val_next  = found_val_reg;
                    res_wt_next   = found_wt_reg;
                    state_next    = ST_EMIT_FIRST;
                end
            end

            ST_INS_SHIFT:
            begin
                wr_en  = 1'b1;
                wr_idx = idx_reg[IDX_W-1:0];
                if (idx_reg == '0)
                begin
                    // Place the new entry at the front.
                    used_next     = used_reg + 1'b1;
                    sum_next      = sum_reg + SUM_W'(wt_reg);
                    top_next      = used_reg + 1'b1;
                    res_kind_next = wbsfc_pkg::KIND_INSERTED;
                    res_val_next  = val_reg;
                    res_wt_next   = wt_reg;
                    state_next    = ST_EVICT;
                end
                else
                begin
                    wr_key   = rd_key_reg;
                    wr_val   = rd_val_reg;
                    wr_wt    = rd_wt_reg;
                    idx_next = idx_reg - 1'b1;
                end
            end

            ST_DEL_SHIFT:
            begin
                if (CNT_W'(idx_reg + 1'b1) < used_reg)
                begin
                    wr_en    = 1'b1;
                    wr_idx   = idx_reg[IDX_W-1:0];
                    wr_key   = rd_key_reg;
                    wr_val   = rd_val_reg;
                    wr_wt    = rd_wt_reg;
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    used_next  = used_reg - 1'b1;
                    top_next   = used_reg - 1'b1;
                    state_next = ST_EMIT_FIRST;
                end
            end

            ST_EVICT:
            begin
                // Trim from the back; the slots stay intact for the beats.
                if (over_limit)
                begin
                    sum_next  = sum_reg - SUM_W'(rd_wt_reg);
                    used_next = used_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT_FIRST;
                end
            end

            ST_EMIT_FIRST:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = res_kind_reg;
                    out_key_next    = key_reg;
                    out_value_next  = res_val_reg;
                    out_weight_next = res_wt_reg;
                    out_last_next   = (top_reg == used_reg);
                    out_count_next  = used_reg;
                    out_sum_next    = sum_reg;
                    state_next      = (top_reg == used_reg) ? ST_IDLE : ST_EMIT_EVICT;
                end
            end

            ST_EMIT_EVICT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = wbsfc_pkg::KIND_EVICTED;
                    out_key_next    = rd_key_reg;
                    out_value_next  = rd_val_reg;
                    out_weight_next = rd_wt_reg;
                    out_last_next   = (CNT_W'(top_reg - 1'b1) == used_reg);
                    out_count_next  = used_reg;
                    out_sum_next    = sum_reg;
                    top_next        = top_reg - 1'b1;
                    if (CNT_W'(top_reg - 1'b1) == used_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cmd_reg         <= wbsfc_pkg::CMD_LOOKUP;
            key_reg         <= '0;
            val_reg         <= '0;
            wt_reg          <= '0;
            idx_reg         <= '0;
            used_reg        <= '0;
            sum_reg         <= '0;
            top_reg         <= '0;
            found_val_reg   <= '0;
            found_wt_reg    <= '0;
            res_kind_reg    <= wbsfc_pkg::KIND_HIT;
            res_val_reg     <= '0;
            res_wt_reg      <= '0;
            max_entries_reg <= wbsfc_pkg::MAXE_RESET;
            mem_limit_reg   <= wbsfc_pkg::MLIM_RESET;
            out_valid_reg   <= 1'b0;
            out_kind_reg    <= wbsfc_pkg::KIND_HIT;
            out_key_reg     <= '0;
            out_value_reg   <= '0;
            out_weight_reg  <= '0;
            out_last_reg    <= 1'b0;
            out_count_reg   <= '0;
            out_sum_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cmd_reg         <= cmd_next;
            key_reg         <= key_next;
            val_reg         <= val_next;
            wt_reg          <= wt_next;
            idx_reg         <= idx_next;
            used_reg        <= used_next;
            sum_reg         <= sum_next;
            top_reg         <= top_next;
            found_val_reg   <= found_val_next;
            found_wt_reg    <= found_wt_next;
            res_kind_reg    <= res_kind_next;
            res_val_reg     <= res_val_next;
            res_wt_reg      <= res_wt_next;
            max_entries_reg <= max_entries_next;
            mem_limit_reg   <= mem_limit_next;
            out_valid_reg   <= out_valid_next;
            out_kind_reg    <= out_kind_next;
            out_key_reg     <= out_key_next;
            out_value_reg   <= out_value_next;
            out_weight_reg  <= out_weight_next;
            out_last_reg    <= out_last_next;
            out_count_reg   <= out_count_next;
            out_sum_reg     <= out_sum_next;
        end
    end

    // Slot store: one write port and one registered read port. A read of the slot
    // being written in the same cycle returns the new data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_key_mem[wr_idx]    <= wr_key;
            slot_value_mem[wr_idx]  <= wr_val;
            slot_weight_mem[wr_idx] <= wr_wt;
        end
        if (wr_en && (wr_idx == rd_idx))
        begin
            rd_key_reg <= wr_key;
            rd_val_reg <= wr_val;
            rd_wt_reg  <= wr_wt;
        end
        else
        begin
            rd_key_reg <= slot_key_mem[rd_idx];
            rd_val_reg <= slot_value_mem[rd_idx];
            rd_wt_reg  <= slot_weight_mem[rd_idx];
        end
    end

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.kind        = out_kind_reg;
    assign rsp.out_key     = out_key_reg;
    assign rsp.out_value   = out_value_reg;
    assign rsp.out_weight  = out_weight_reg;
    assign rsp.last        = out_last_reg;
    assign rsp.entry_count = wbsfc_pkg::ENTRY_W'(out_count_reg);
    assign rsp.total_bytes = out_sum_reg;

endmodule
